### rtl/lnse_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian noise sigma estimate: shared definitions
// Field widths, register indexes, sizing defaults and the fixed-point
// constant used to turn the absolute response sum into a sigma value.
// ----------------------------------------------------------------------------
package lnse_pkg;

	// Default sizing of the block.
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;
	localparam int unsigned DEF_PIXEL_BITS = 16;

	// Configuration register fields.
	localparam int unsigned FW_W = 11;
	localparam int unsigned FH_W = 13;
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);
	localparam int unsigned MIN_SIZE = 3;

	// Register indexes, selected by address bit 2.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Result fields.
	localparam int unsigned SUM_W   = 48;
	localparam int unsigned SIGMA_W = 26;
	localparam int unsigned COUNT_W = 22;

	// sqrt(pi/2)/6 in Q0.32, rounded.
	localparam int unsigned K_W = 30;
	localparam logic [K_W-1:0] SIGMA_K = K_W'(897157205);

	// Product arithmetic: sum = s1:s0 with s0 32 bits and s1 16 bits.
	localparam int unsigned SLO_W  = 32;
	localparam int unsigned SHI_W  = SUM_W - SLO_W;
	localparam int unsigned P0_W   = SLO_W + K_W + 1;
	localparam int unsigned P1_W   = SHI_W + K_W;
	localparam int unsigned NUM_W  = SUM_W + K_W + 1;
	// Divisor is count * 2^24; half of it is count * 2^23.
	localparam int unsigned DSH    = 24;
	localparam int unsigned RND_SH = DSH - 1;
	localparam int unsigned NUMS_W = NUM_W - DSH;
	localparam int unsigned NHI_W  = NUMS_W - SIGMA_W;
	localparam int unsigned DCNT_W = $clog2(SIGMA_W);

endpackage

### rtl/laplacian_noise_sigma_estimate_top.sv
// ----------------------------------------------------------------------------
// Laplacian noise sigma estimate
// Streams a frame through two line stores and a 3x3 window, sums the
// absolute Laplacian-difference response over interior pixels and gives
// the sum, the interior pixel count and the noise sigma at frame end.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the input channel (in_valid / in_stall).
// frame_start on a pixel restarts the position and the sum at that pixel.
// The frame size comes from the frame_width and frame_height registers on
// the APB port; sizes are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT].
// Each pixel is read, then processed: its column is read from the line-store
// memory when it is accepted, then the window is updated and the column is
// written back, and the input stalls until that is done.
// The last pixel of a frame starts the sigma computation: two partial
// products, a rounding add, a saturation check and a 26-step restoring
// divider. The result item is loaded into the output register once the
// divider finishes (straight after the check when sigma saturates), and
// no pixel is accepted during that time.
// A stalled output holds its item; pixels of the next frame are still
// accepted. If a second frame ends before the first result is taken, the
// input stalls until the output register is free.
// Reset clears the window, the position, the sum and the output; the
// line-store memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module laplacian_noise_sigma_estimate_top #(
	parameter int unsigned MAX_WIDTH  = lnse_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = lnse_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned PIXEL_BITS = lnse_pkg::DEF_PIXEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// Pixel channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [PIXEL_BITS-1:0]        pixel,
	input  logic                         frame_start,
	// Result channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lnse_pkg::SIGMA_W-1:0] sigma_estimate,
	output logic [lnse_pkg::SUM_W-1:0]   response_sum,
	output logic [lnse_pkg::COUNT_W-1:0] interior_count
);
	import lnse_pkg::*;

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned WV_W  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HV_W  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CNT_W = WV_W + HV_W;
	localparam int unsigned RW    = PIXEL_BITS + 4;
	localparam int unsigned MAG_W = PIXEL_BITS + 3;
	localparam int unsigned MEM_W = 2 * PIXEL_BITS;

	// Controller states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PIX  = 3'd1;
	localparam logic [2:0] ST_MUL0 = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_PREP = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]            state_q;
	logic [FW_W-1:0]       cfg_width_q;
	logic [FH_W-1:0]       cfg_height_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [SUM_W-1:0]      acc_q;
	logic [PIXEL_BITS-1:0] px_q;
	logic [PIXEL_BITS-1:0] win_q [3][2];
	logic [MEM_W-1:0]      mem [MAX_WIDTH];
	logic [MEM_W-1:0]      rd_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q;
	logic [P0_W-1:0]       p0_q;
	logic [P1_W-1:0]       p1_q;
	logic [NUMS_W-1:0]     num_q;
	logic [CNT_W-1:0]      rem_q;
	logic [SIGMA_W-1:0]    lo_q;
	logic [SIGMA_W-1:0]    quo_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  out_valid_q;
	logic [SIGMA_W-1:0]    sigma_out_q;
	logic [SUM_W-1:0]      sum_out_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic                  cfg_wr;
	logic                  in_acc;
	logic [COL_W-1:0]      rd_addr;
	logic [31:0]           w32;
	logic [31:0]           h32;
	logic [WV_W-1:0]       w_c;
	logic [HV_W-1:0]       h_c;
	logic                  col_end;
	logic                  row_end;
	logic                  interior;
	logic [PIXEL_BITS-1:0] new_col [3];
	logic signed [RW-1:0]  r_top;
	logic signed [RW-1:0]  r_mid;
	logic signed [RW-1:0]  r_bot;
	logic signed [RW-1:0]  resp;
	logic [MAG_W-1:0]      mag;
	logic [SUM_W-1:0]      acc_next;
	logic [NUM_W-1:0]      num_full;
	logic [NHI_W-1:0]      num_hi;
	logic [CNT_W:0]        div_t;
	logic [CNT_W:0]        div_d;
	logic                  div_ge;
	logic                  out_free;

	// APB register access.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= FW_RESET;
			cfg_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_height_q <= pwdata[FH_W-1:0];
				default:          cfg_width_q  <= cfg_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(cfg_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(cfg_height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective frame size, clamped to the supported range.
	always_comb begin
		w32 = 32'(cfg_width_q);
		h32 = 32'(cfg_height_q);
		if (w32 < 32'(MIN_SIZE)) begin
			w32 = 32'(MIN_SIZE);
		end else if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		if (h32 < 32'(MIN_SIZE)) begin
			h32 = 32'(MIN_SIZE);
		end else if (h32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end
	end
	assign w_c = w32[WV_W-1:0];
	assign h_c = h32[HV_W-1:0];

	// Handshakes.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Line-store memory: the upper line in the high half, the middle line in
	// the low half. A column is read when its item is accepted and written
	// back in the following cycle, so accesses never overlap.
	assign rd_addr = frame_start ? '0 : col_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= mem[rd_addr];
		end
		if (state_q == ST_PIX) begin
			mem[col_q] <= {rd_q[PIXEL_BITS-1:0], px_q};
		end
	end

	// Window position and mask response for the item in flight.
	assign col_end  = (WV_W'(col_q) + WV_W'(1)) >= w_c;
	assign row_end  = (HV_W'(row_q) + HV_W'(1)) >= h_c;
	assign interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));

	assign new_col[0] = rd_q[MEM_W-1:PIXEL_BITS];
	assign new_col[1] = rd_q[PIXEL_BITS-1:0];
	assign new_col[2] = px_q;

	always_comb begin
		r_top = $signed({4'b0, win_q[0][0]}) - ($signed({4'b0, win_q[0][1]}) <<< 1)
			+ $signed({4'b0, new_col[0]});
		r_mid = $signed({4'b0, win_q[1][0]}) - ($signed({4'b0, win_q[1][1]}) <<< 1)
			+ $signed({4'b0, new_col[1]});
		r_bot = $signed({4'b0, win_q[2][0]}) - ($signed({4'b0, win_q[2][1]}) <<< 1)
			+ $signed({4'b0, new_col[2]});
		resp  = r_top - (r_mid <<< 1) + r_bot;
		mag   = resp[RW-1] ? MAG_W'(-resp) : MAG_W'(resp);
	end
	assign acc_next = interior ? (acc_q + SUM_W'(mag)) : acc_q;

	// Numerator after the rounding add, scaled down by 2^24.
	assign num_full = NUM_W'(p0_q) + (NUM_W'(p1_q) << SLO_W);
	assign num_hi   = num_q[NUMS_W-1:SIGMA_W];

	// One restoring division step.
	assign div_t  = {rem_q, lo_q[SIGMA_W-1]};
	assign div_d  = {1'b0, count_q};
	assign div_ge = div_t >= div_d;

	// Controller, position counters, window and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			acc_q   <= '0;
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (frame_start) begin
							col_q <= '0;
							row_q <= '0;
							acc_q <= '0;
						end
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= new_col[r];
					end
					acc_q   <= acc_next;
					state_q <= ST_IDLE;
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q   <= '0;
							acc_q   <= '0;
							state_q <= ST_MUL0;
						end else begin
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_PREP;
				ST_PREP: begin
					if (32'(num_hi) >= 32'(count_q)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pixel capture and the sigma datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= pixel;
		end
		case (state_q)
			ST_PIX: begin
				sum_q <= acc_next;
			end
			ST_MUL0: begin
				count_q <= CNT_W'(w_c - WV_W'(2)) * CNT_W'(h_c - HV_W'(2));
				p0_q    <= P0_W'(sum_q[SLO_W-1:0]) * P0_W'(SIGMA_K);
			end
			ST_MUL1: begin
				p1_q <= P1_W'(sum_q[SUM_W-1:SLO_W]) * P1_W'(SIGMA_K);
				p0_q <= p0_q + (P0_W'(count_q) << RND_SH);
			end
			ST_ADD: begin
				num_q <= num_full[NUM_W-1:DSH];
			end
			ST_PREP: begin
				rem_q  <= CNT_W'(num_hi);
				lo_q   <= num_q[SIGMA_W-1:0];
				quo_q  <= '1;
				dcnt_q <= DCNT_W'(SIGMA_W - 1);
			end
			ST_DIV: begin
				rem_q  <= div_ge ? CNT_W'(div_t - div_d) : CNT_W'(div_t);
				quo_q  <= {quo_q[SIGMA_W-2:0], div_ge};
				lo_q   <= lo_q << 1;
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			sigma_out_q <= quo_q;
			sum_out_q   <= sum_q;
			count_out_q <= COUNT_W'(count_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign sigma_estimate = sigma_out_q;
	assign response_sum   = sum_out_q;
	assign interior_count = count_out_q;

	// An accepted item is always processed in the next cycle.
	a_acc_to_pix: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_PIX))
		else $error("accepted item not processed in the next cycle");

	// The divider remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < count_q))
		else $error("divider remainder out of range");

	// A new result appears only from the output-load state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output-load state");

endmodule

### tb/laplacian_noise_sigma_estimate_top_tb.sv
// ----------------------------------------------------------------------------
// Laplacian noise sigma estimate testbench
// Streams frames of pixels into the block through its valid/stall channel,
// keeps its own copy of the line stores, window and response sum, and
// compares each frame result (sigma, sum, interior count) with the value
// it works out. Frame sizes are changed over the APB port between bursts
// of frames, including sizes that clamp to the minimum. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module laplacian_noise_sigma_estimate_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lnse_pkg::*;

	localparam int unsigned PIX_W          = DEF_PIXEL_BITS;
	localparam int unsigned MAXW           = DEF_MAX_WIDTH;
	localparam int unsigned MAXH           = DEF_MAX_HEIGHT;
	// sqrt(pi/2)/6 scaled by 2^32 and rounded.
	localparam longint unsigned SIGMA_SCALE = 64'd897157205;
	localparam logic [SIGMA_W-1:0] SIGMA_CEIL = {SIGMA_W{1'b1}};
	// Quiet time that drain() waits after every pending result has come in.
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS   = 1530;
	localparam int unsigned QUIET_AFTER    = 1300;

	typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_NEAR_BASE, PIX_FLAT} pixel_mode_t;

	typedef struct packed {
		logic [SIGMA_W-1:0] sigma;
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} frame_result_t;

	// Tracks the frame position and response sum, and holds the results
	// that accepted pixels have made due.
	class frame_sigma_checker_t;
		logic [FW_W-1:0] width_reg;
		logic [FH_W-1:0] height_reg;
		bit [PIX_W-1:0] upper_line [MAXW];
		bit [PIX_W-1:0] middle_line [MAXW];
		bit [PIX_W-1:0] win [9];
		int unsigned col;
		int unsigned row;
		logic [SUM_W-1:0] acc;
		frame_result_t pending_frames [$];
		int mismatches;

		function new();
			width_reg = FW_RESET;
			height_reg = FH_RESET;
			col = 0;
			row = 0;
			acc = '0;
			mismatches = 0;
		endfunction

		function void set_size(logic idx, logic [31:0] val);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = val[FW_W-1:0];
			end else begin
				height_reg = val[FH_W-1:0];
			end
		endfunction

		function void take_pixel(logic [PIX_W-1:0] px, logic fs);
			int unsigned w;
			int unsigned h;
			int unsigned col_idx;
			int unsigned cnt;
			int resp;
			logic [127:0] num;
			logic [127:0] den;
			frame_result_t res;
			w = (width_reg < MIN_SIZE) ? MIN_SIZE : (width_reg > MAXW ? MAXW : width_reg);
			h = (height_reg < MIN_SIZE) ? MIN_SIZE : (height_reg > MAXH ? MAXH : height_reg);
			if (fs) begin
				col = 0;
				row = 0;
				acc = '0;
			end
			col_idx = (col < MAXW) ? col : MAXW - 1;

			// Shift the window left and bring in the new column.
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = upper_line[col_idx];
			win[5] = middle_line[col_idx];
			win[8] = px;
			upper_line[col_idx] = middle_line[col_idx];
			middle_line[col_idx] = px;

			// Interior pixels add the absolute mask response.
			if (col >= 2 && row >= 2) begin
				resp = int'(win[0]) - 2*int'(win[1]) + int'(win[2])
					- 2*int'(win[3]) + 4*int'(win[4]) - 2*int'(win[5])
					+ int'(win[6]) - 2*int'(win[7]) + int'(win[8]);
				acc = acc + SUM_W'((resp < 0) ? -resp : resp);
			end

			// Advance the position; the last pixel of the frame makes a result.
			if (col + 1 >= w) begin
				col = 0;
				if (row + 1 >= h) begin
					cnt = (w - 2) * (h - 2);
					den = 128'(cnt) << 24;
					num = 128'(acc) * 128'(SIGMA_SCALE) + (den >> 1);
					num = num / den;
					res.sigma = (num > 128'(SIGMA_CEIL)) ? SIGMA_CEIL : num[SIGMA_W-1:0];
					res.sum = acc;
					res.count = COUNT_W'(cnt);
					pending_frames = {pending_frames, res};
					row = 0;
					acc = '0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
			end
		endfunction

		function void check_frame_result(frame_result_t got);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with none pending, sum %0d", $realtime, got.sum);
				end
				return;
			end
			want = pending_frames.pop_front();
			if (got.sigma !== want.sigma) flag("sigma_estimate", want.sigma, got.sigma);
			if (got.sum !== want.sum) flag("response_sum", want.sum, got.sum);
			if (got.count !== want.count) flag("interior_count", want.count, got.count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [PIX_W-1:0] pixel;
	logic frame_start;
	logic out_valid;
	logic out_stall;
	logic [SIGMA_W-1:0] sigma_estimate;
	logic [SUM_W-1:0] response_sum;
	logic [COUNT_W-1:0] interior_count;

	frame_sigma_checker_t sb = new();
	bit idle_on = 1'b1;
	int unsigned gap_pct = 25;
	int unsigned random_sent = 0;
	int unsigned stuck_cycles = 0;

	laplacian_noise_sigma_estimate_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel         (pixel),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sigma_estimate(sigma_estimate),
		.response_sum  (response_sum),
		.interior_count(interior_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Feed accepted pixels to the predictor and check accepted results.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.take_pixel(pixel, frame_start);
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_frame_result('{sigma_estimate, response_sum, interior_count});
		end
	end

	// End the run when nothing has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// The result side stalls in random bursts while idling is enabled.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_size(idx, val);
	endtask

	// Offer one pixel, maybe after a gap, and return at the falling edge
	// after it has been taken. Valid stays high for a following item.
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		frame_start <= fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending until every pending result is in and the block is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_frames.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] gen_pixel(pixel_mode_t mode, logic [PIX_W-1:0] base);
		int v;
		case (mode)
			PIX_EXTREME: begin
				return ($urandom_range(0, 1) != 0) ? {PIX_W{1'b1}} : '0;
			end
			PIX_NEAR_BASE: begin
				v = int'(base) + int'($urandom_range(0, 128)) - 64;
				if (v < 0) v = 0;
				if (v > int'({PIX_W{1'b1}})) v = int'({PIX_W{1'b1}});
				return v[PIX_W-1:0];
			end
			PIX_FLAT: begin
				return base;
			end
			default: begin
				return PIX_W'($urandom);
			end
		endcase
	endfunction

	task automatic send_frame(input int unsigned n_pix, input pixel_mode_t mode,
			input bit mark_start);
		logic [PIX_W-1:0] base;
		base = PIX_W'($urandom);
		for (int i = 0; i < n_pix; i++) begin
			send_pixel(gen_pixel(mode, base), mark_start && i == 0);
		end
	endtask

	initial begin
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned n_frames;
		int unsigned n_pix;
		int unsigned n_cut;
		bit cut_short;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Smallest frame, reached through clamping of too-small sizes.
		write_reg(REG_FRAME_WIDTH, 32'd0);
		write_reg(REG_FRAME_HEIGHT, 32'd2);
		// A frame abandoned after three pixels, restarted by frame_start.
		for (int i = 0; i < 3; i++) send_pixel({PIX_W{1'b1}}, i == 0);
		// Checkerboard with full-scale corners and center: largest positive response.
		for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? {PIX_W{1'b1}} : '0, i == 0);
		// Inverse checkerboard, with no frame_start: the frame end restarts the position.
		for (int i = 0; i < 9; i++) send_pixel((i % 2 == 1) ? {PIX_W{1'b1}} : '0, 1'b0);
		drain();

		// Random bursts of frames, a new frame size for each burst.
		while (random_sent < RANDOM_ITEMS) begin
			idle_on = (random_sent < QUIET_AFTER);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 30;
			endcase
			w_eff = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
			h_eff = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(3, 6);
			write_reg(REG_FRAME_WIDTH, (w_eff == 3 && $urandom_range(0, 1) != 0) ?
				$urandom_range(0, 2) : w_eff);
			write_reg(REG_FRAME_HEIGHT, (h_eff == 3 && $urandom_range(0, 1) != 0) ?
				$urandom_range(0, 2) : h_eff);
			n_frames = $urandom_range(1, 4);
			cut_short = 1'b0;
			for (int f = 0; f < n_frames; f++) begin
				// After an abandoned frame the next one must restart explicitly.
				n_pix = w_eff * h_eff;
				if (f + 1 < n_frames && $urandom_range(0, 7) == 0) begin
					n_cut = $urandom_range(1, n_pix - 1);
					send_frame(n_cut, pixel_mode_t'($urandom_range(0, 3)),
						cut_short || ($urandom_range(0, 1) != 0));
					cut_short = 1'b1;
					random_sent += n_cut;
				end else begin
					send_frame(n_pix, pixel_mode_t'($urandom_range(0, 3)),
						cut_short || ($urandom_range(0, 3) != 0));
					cut_short = 1'b0;
					random_sent += n_pix;
				end
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/lnse_pkg.sv
rtl/laplacian_noise_sigma_estimate_top.sv
tb/laplacian_noise_sigma_estimate_top_tb.sv
